// ===== src/cptr_pkg.sv =====
package cptr_pkg;

	// Quotient bits of the raster divide; terms are capped at 2^42
	localparam int QBITS = 43;
	localparam logic [QBITS-1:0] TERM_CAP = {1'b1, {(QBITS-1){1'b0}}};
	localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_APERTURE = 3'd0,
		CFG_FOCAL    = 3'd1,
		CFG_ASPECT   = 3'd2,
		CFG_WIDTH    = 3'd3,
		CFG_HEIGHT   = 3'd4,
		CFG_SHIFT_X  = 3'd5,
		CFG_SHIFT_Y  = 3'd6,
		CFG_ORTHO    = 3'd7
	} cfg_idx_t;

	// Point fields carried around the depth divider
	typedef struct packed {
		logic        behind;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
	} head_t;

	// Per-item flags and depth carried to the output stage
	typedef struct packed {
		logic        behind;
		logic        neg_x;
		logic        neg_y;
		logic [31:0] depth;
	} tail_t;

endpackage

// ===== src/cptr_if.sv =====
interface cptr_point_if;
	logic        valid;
	logic        ready;
	logic [31:0] point_x;
	logic [31:0] point_y;
	logic [31:0] point_z;
	modport source (output valid, point_x, point_y, point_z, input ready);
	modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

interface cptr_raster_if;
	logic        valid;
	logic        ready;
	logic [31:0] raster_x;
	logic [31:0] raster_y;
	logic [31:0] depth_out;
	logic        behind_camera;
	modport source (output valid, raster_x, raster_y, depth_out, behind_camera, input ready);
	modport sink (input valid, raster_x, raster_y, depth_out, behind_camera, output ready);
endinterface

interface cptr_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== src/cptr_dly.sv =====
module cptr_dly #(
	parameter int W = 8,
	parameter int N = 2
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] line_s [N];

	// Shift line, moves with the pipeline
	always_ff @(posedge clk) begin
		if (en) begin
			line_s[0] <= d;
			for (int i = 1; i < N; i++) line_s[i] <= line_s[i-1];
		end
	end

	assign q = line_s[N-1];

endmodule

// ===== src/cptr_mul.sv =====
module cptr_mul #(
	parameter int AW = 33,
	parameter int BW = 32
) (
	input  logic             clk,
	input  logic             en,
	input  logic [AW-1:0]    a,
	input  logic [BW-1:0]    b,
	output logic [AW+BW-1:0] p
);

	localparam int NL = (AW + 31) / 32;
	localparam int PW = AW + BW;

	logic [NL*32-1:0] a_ext;
	logic [31+BW:0]   pp_s1 [NL];
	logic [PW-1:0]    sum;
	logic [PW-1:0]    p_s2;

	assign a_ext = (NL*32)'(a);

	// Stage 1: one 32-bit limb of a times b per lane
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NL; i++)
				pp_s1[i] <= (32+BW)'(a_ext[i*32 +: 32]) * (32+BW)'(b);
		end
	end

	// Stage 2: align and add the lane products
	always_comb begin
		sum = '0;
		for (int i = 0; i < NL; i++) sum = sum + (PW'(pp_s1[i]) << (32*i));
	end

	always_ff @(posedge clk) begin
		if (en) p_s2 <= sum;
	end

	assign p = p_s2;

endmodule

// ===== src/cptr_div.sv =====
module cptr_div #(
	parameter int QW = 43,
	parameter int DW = 31,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          en,
	input  logic [DW-1:0] r0,
	input  logic [QW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side_i,
	output logic [QW-1:0] q,
	output logic [SW-1:0] side_o
);

	// One restoring step per stage; num shifts out on top, quotient in below
	logic [DW-1:0] rem_s  [QW];
	logic [QW-1:0] num_s  [QW];
	logic [DW-1:0] den_s  [QW];
	logic [SW-1:0] side_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [DW-1:0] rin;
		logic [QW-1:0] nin;
		logic [DW-1:0] din;
		logic [SW-1:0] sin;
		logic [DW:0]   t;
		logic          ge;

		if (k == 0) begin : g_first
			assign rin = r0;
			assign nin = num;
			assign din = den;
			assign sin = side_i;
		end else begin : g_next
			assign rin = rem_s[k-1];
			assign nin = num_s[k-1];
			assign din = den_s[k-1];
			assign sin = side_s[k-1];
		end

		assign t  = {rin, nin[QW-1]};
		assign ge = t >= {1'b0, din};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? DW'(t - {1'b0, din}) : t[DW-1:0];
				num_s[k]  <= {nin[QW-2:0], ge};
				den_s[k]  <= din;
				side_s[k] <= sin;
			end
		end
	end

	assign q      = num_s[QW-1];
	assign side_o = side_s[QW-1];

endmodule

// ===== src/cptr_rnd.sv =====
module cptr_rnd import cptr_pkg::*; #(
	parameter int PW = 96,
	parameter int SH = 16
) (
	input  logic             clk,
	input  logic             en,
	input  logic [PW-1:0]    p,
	input  logic [30:0]      d,
	output logic [30:0]      r0,
	output logic [QBITS-1:0] lo,
	output logic             ovf
);

	localparam int NW = PW + 1 - SH;
	localparam int HW = NW - QBITS;

	logic [PW:0]        sum;
	logic [NW-1:0]      n_s1;
	logic [HW-1:0]      hi;
	logic [30:0]        r0_s2;
	logic [QBITS-1:0]   lo_s2;
	logic               ovf_s2;

	// Stage 1: add half the divisor and drop the power-of-two part of it
	assign sum = (PW+1)'(p) + ((PW+1)'(d) << (SH - 1));

	always_ff @(posedge clk) begin
		if (en) n_s1 <= sum[PW:SH];
	end

	// Stage 2: quotient would exceed the cap when the top part reaches d
	assign hi = n_s1[NW-1:QBITS];

	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s2 <= hi >= HW'(d);
			r0_s2  <= hi[30:0];
			lo_s2  <= n_s1[QBITS-1:0];
		end
	end

	assign r0  = r0_s2;
	assign lo  = lo_s2;
	assign ovf = ovf_s2;

endmodule

// ===== src/camera_point_to_raster_core.sv =====
// The depth divider stays 32 steps deep while FRAC_BITS is below 16.
// Throughput: one point per cycle; the divider and multiplier chains are fully pipelined.
// The whole pipeline stalls only while a finished beat waits at the output.
// Reset (arst_n low) clears valid bits and loads the default camera registers.
module camera_point_to_raster_core import cptr_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	cptr_cfg_if.sink      cfg,
	cptr_point_if.sink    point,
	cptr_raster_if.source raster
);

	localparam int WW   = 2*FRAC_BITS + 1;
	localparam int NW0  = (WW > 32) ? WW : 32;
	localparam int A1W  = WW + 32;
	localparam int A2W  = A1W + 31;
	localparam int PXW  = A2W + 16;
	localparam int AYW  = A2W + 31;
	localparam int PYW  = AYW + 16;
	localparam int L    = NW0 + 56;

	// Camera registers
	logic [30:0]        aperture_q, focal_q, aspect_q;
	logic [15:0]        width_q, height_q;
	logic signed [31:0] shift_x_q, shift_y_q;
	logic               ortho_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aperture_q <= 31'(1) << FRAC_BITS;
			focal_q    <= 31'(1) << FRAC_BITS;
			aspect_q   <= 31'(1) << FRAC_BITS;
			width_q    <= 16'd640;
			height_q   <= 16'd480;
			shift_x_q  <= '0;
			shift_y_q  <= '0;
			ortho_q    <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg_idx_t'(cfg.index))
				CFG_APERTURE: aperture_q <= cfg.data[30:0];
				CFG_FOCAL:    focal_q    <= cfg.data[30:0];
				CFG_ASPECT:   aspect_q   <= cfg.data[30:0];
				CFG_WIDTH:    width_q    <= cfg.data[15:0];
				CFG_HEIGHT:   height_q   <= cfg.data[15:0];
				CFG_SHIFT_X:  shift_x_q  <= cfg.data;
				CFG_SHIFT_Y:  shift_y_q  <= cfg.data;
				CFG_ORTHO:    ortho_q    <= cfg.data[0];
			endcase
		end
	end

	logic [30:0] dvs;
	assign dvs = (aperture_q == '0) ? 31'd1 : aperture_q;

	// Pipeline control: everything advances together unless the output is held
	logic         en;
	logic [L-1:0] vld_s;

	assign en          = !raster.valid || raster.ready;
	assign point.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s <= '0;
		else if (en) vld_s <= {vld_s[L-2:0], point.valid};
	end

	// Stage 1: depth divisor and rounded numerator 2^(2F) + den/2
	head_t          head_s1;
	logic [31:0]    den_s1;
	logic [NW0-1:0] num_s1;
	logic [31:0]    den_in;

	assign den_in = 32'(-point.point_z);

	always_ff @(posedge clk) begin
		if (en) begin
			head_s1.behind <= !ortho_q && !point.point_z[31];
			head_s1.x      <= point.point_x;
			head_s1.y      <= point.point_y;
			head_s1.z      <= point.point_z;
			den_s1         <= den_in;
			num_s1         <= (NW0'(1) << (2*FRAC_BITS)) + NW0'(den_in[31:1]);
		end
	end

	// Depth divider: w = round(2^(2F) / -z)
	logic [NW0-1:0] q_w;
	head_t          head_d;

	cptr_div #(.QW(NW0), .DW(32), .SW($bits(head_t))) u_div_w (
		.clk    (clk),
		.en     (en),
		.r0     (32'd0),
		.num    (num_s1),
		.den    (den_s1),
		.side_i (head_s1),
		.q      (q_w),
		.side_o (head_d)
	);

	// Select w and depth, split coordinates into sign and magnitude
	logic [WW-1:0] w_ws;
	logic [31:0]   mag_x_ws, mag_y_ws;
	tail_t         tail_ws;

	always_ff @(posedge clk) begin
		if (en) begin
			w_ws           <= ortho_q ? (WW'(1) << FRAC_BITS) : q_w[WW-1:0];
			mag_x_ws       <= head_d.x[31] ? 32'(-head_d.x) : head_d.x;
			mag_y_ws       <= head_d.y[31] ? 32'(-head_d.y) : head_d.y;
			tail_ws.behind <= head_d.behind;
			tail_ws.neg_x  <= head_d.x[31];
			tail_ws.neg_y  <= head_d.y[31];
			if (ortho_q)
				tail_ws.depth <= head_d.z;
			else if (q_w > NW0'(S32_MAX))
				tail_ws.depth <= S32_MAX;
			else
				tail_ws.depth <= q_w[31:0];
		end
	end

	// Product chains: x = w*|x|*focal*width, y = w*|y|*focal*aspect*height
	logic [A1W-1:0] m1x, m1y;
	logic [A2W-1:0] m2x, m2y;
	logic [PXW-1:0] m3x, px;
	logic [AYW-1:0] m3y;
	logic [PYW-1:0] py;

	cptr_mul #(.AW(WW),  .BW(32)) u_m1x (.clk(clk), .en(en), .a(w_ws), .b(mag_x_ws), .p(m1x));
	cptr_mul #(.AW(A1W), .BW(31)) u_m2x (.clk(clk), .en(en), .a(m1x),  .b(focal_q),  .p(m2x));
	cptr_mul #(.AW(A2W), .BW(16)) u_m3x (.clk(clk), .en(en), .a(m2x),  .b(width_q),  .p(m3x));
	cptr_dly #(.W(PXW), .N(2))    u_dx  (.clk(clk), .en(en), .d(m3x),  .q(px));

	cptr_mul #(.AW(WW),  .BW(32)) u_m1y (.clk(clk), .en(en), .a(w_ws), .b(mag_y_ws), .p(m1y));
	cptr_mul #(.AW(A1W), .BW(31)) u_m2y (.clk(clk), .en(en), .a(m1y),  .b(focal_q),  .p(m2y));
	cptr_mul #(.AW(A2W), .BW(31)) u_m3y (.clk(clk), .en(en), .a(m2y),  .b(aspect_q), .p(m3y));
	cptr_mul #(.AW(AYW), .BW(16)) u_m4y (.clk(clk), .en(en), .a(m3y),  .b(height_q), .p(py));

	// Flags and depth wait alongside the products and rounding
	tail_t tail_d;
	cptr_dly #(.W($bits(tail_t)), .N(10)) u_dtail (
		.clk (clk), .en (en), .d (tail_ws), .q (tail_d)
	);

	// Rounding offset and cap test
	logic [30:0]      r0x, r0y;
	logic [QBITS-1:0] lox, loy;
	logic             ovfx, ovfy;

	cptr_rnd #(.PW(PXW), .SH(FRAC_BITS)) u_rx (
		.clk(clk), .en(en), .p(px), .d(dvs), .r0(r0x), .lo(lox), .ovf(ovfx)
	);
	cptr_rnd #(.PW(PYW), .SH(2*FRAC_BITS)) u_ry (
		.clk(clk), .en(en), .p(py), .d(dvs), .r0(r0y), .lo(loy), .ovf(ovfy)
	);

	// Divide by the aperture
	logic [QBITS-1:0] qx, qy;
	tail_t            tail_q;
	logic             ovfx_q, ovfy_q;

	cptr_div #(.QW(QBITS), .DW(31), .SW($bits(tail_t) + 1)) u_div_x (
		.clk    (clk),
		.en     (en),
		.r0     (r0x),
		.num    (lox),
		.den    (dvs),
		.side_i ({ovfx, tail_d}),
		.q      (qx),
		.side_o ({ovfx_q, tail_q})
	);

	cptr_div #(.QW(QBITS), .DW(31), .SW(1)) u_div_y (
		.clk    (clk),
		.en     (en),
		.r0     (r0y),
		.num    (loy),
		.den    (dvs),
		.side_i (ovfy),
		.q      (qy),
		.side_o (ovfy_q)
	);

	// Cap, sign, add center minus offset, saturate
	function automatic logic [31:0] place(
		input logic [QBITS-1:0] q,
		input logic             ovf,
		input logic             neg,
		input logic [15:0]      res,
		input logic signed [31:0] sh
	);
		logic [QBITS-1:0]   t;
		logic signed [47:0] s;
		t = (ovf || q > TERM_CAP) ? TERM_CAP : q;
		s = neg ? -$signed(48'(t)) : $signed(48'(t));
		s = s + $signed(48'(res) << (FRAC_BITS - 1)) - 48'(sh);
		if (s > $signed(48'(S32_MAX)))
			return S32_MAX;
		else if (s < -$signed(48'(S32_MAX)) - 48'sd1)
			return ~S32_MAX;
		else
			return s[31:0];
	endfunction

	logic [31:0] out_x_q, out_y_q, out_d_q;
	logic        out_b_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (tail_q.behind) begin
				out_x_q <= S32_MAX;
				out_y_q <= S32_MAX;
				out_d_q <= S32_MAX;
			end else begin
				out_x_q <= place(qx, ovfx_q, tail_q.neg_x, width_q, shift_x_q);
				out_y_q <= place(qy, ovfy_q, tail_q.neg_y, height_q, shift_y_q);
				out_d_q <= tail_q.depth;
			end
			out_b_q <= tail_q.behind;
		end
	end

	assign raster.valid         = vld_s[L-1];
	assign raster.raster_x      = out_x_q;
	assign raster.raster_y      = out_y_q;
	assign raster.depth_out     = out_d_q;
	assign raster.behind_camera = out_b_q;

	// A behind-camera beat carries saturated values everywhere
	a_behind_sat: assert property (@(posedge clk) disable iff (!arst_n)
		raster.valid && raster.behind_camera |->
		raster.raster_x == S32_MAX && raster.raster_y == S32_MAX &&
		raster.depth_out == S32_MAX)
		else $error("behind-camera beat not saturated");

	// Orthographic mode never flags a point as behind the camera
	a_behind_persp: assert property (@(posedge clk) disable iff (!arst_n)
		raster.valid && raster.behind_camera |-> !ortho_q)
		else $error("behind flag in orthographic mode");

	// A held output freezes every valid bit in the pipeline
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> vld_s == $past(vld_s))
		else $error("pipeline moved during stall");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import cptr_pkg::*;

	localparam int FRAC = 16;
	localparam int DRAIN_CYCLES = 200;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RAND_POINTS = 1540;
	localparam int NUM_PHASES = 7;

	typedef struct packed {
		logic [31:0] rx;
		logic [31:0] ry;
		logic [31:0] depth;
		logic        behind;
	} raster_beat_t;

	typedef struct packed {
		logic [31:0]  x;
		logic [31:0]  y;
		logic [31:0]  z;
		logic         known;
		raster_beat_t res;
	} point_case_t;

	logic clk;
	logic arst_n;

	cptr_cfg_if    cfg ();
	cptr_point_if  point ();
	cptr_raster_if raster ();

	camera_point_to_raster_core #(.FRAC_BITS(FRAC)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg.sink),
		.point  (point.sink),
		.raster (raster.source)
	);

	// Camera register copy used for prediction
	logic [30:0]        cam_aperture;
	logic [30:0]        cam_focal;
	logic [30:0]        cam_aspect;
	logic [15:0]        cam_width;
	logic [15:0]        cam_height;
	logic signed [31:0] cam_shift_x;
	logic signed [31:0] cam_shift_y;
	logic               cam_ortho;

	raster_beat_t pending_rasters[$];
	int  cycle_count;
	int  burst_left;
	int  hold_cycles;
	bit  hold_request;
	bit  failed;

	// Directed points under the reset camera; known rows carry their expected raster beat
	localparam point_case_t DIRECTED[10] = '{
		'{32'h0000_0000, 32'h0000_0000, 32'hFFFF_0000, 1'b1,
			'{32'h0140_0000, 32'h00F0_0000, 32'h0001_0000, 1'b0}},
		'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1,
			'{S32_MAX, S32_MAX, S32_MAX, 1'b1}},
		'{32'h0000_0005, 32'hFFFF_FFFB, 32'h7FFF_FFFF, 1'b1,
			'{S32_MAX, S32_MAX, S32_MAX, 1'b1}},
		'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
		'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, '0},
		'{32'h0001_0000, 32'hFFFF_0000, 32'hFFFE_0000, 1'b0, '0},
		'{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFE, 1'b0, '0},
		'{32'h0003_8000, 32'hFFFC_8000, 32'hFFFF_FFFD, 1'b0, '0},
		'{32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_0000, 1'b0, '0},
		'{32'h0012_3456, 32'hFFED_CBAA, 32'hFFF8_7654, 1'b0, '0}
	};

	// Exact scaled term: round(w*mag*f1*f2*f3 / (aperture * 2^sh)), capped
	function automatic logic [63:0] scaled_term(logic [32:0] w, logic [31:0] mag,
			logic [31:0] f1, logic [31:0] f2, logic [31:0] f3, int sh);
		logic [191:0] prod;
		logic [191:0] div;
		div = (cam_aperture == 0) ? 192'd1 : 192'(cam_aperture);
		prod = 192'(w);
		prod = prod * 192'(mag);
		prod = prod * 192'(f1);
		prod = prod * 192'(f2);
		prod = prod * 192'(f3);
		prod = prod + (div << (sh - 1));
		prod = prod / div;
		prod = prod >> sh;
		if (prod > 192'(TERM_CAP))
			prod = 192'(TERM_CAP);
		return prod[63:0];
	endfunction

	// One raster coordinate: signed term plus half resolution minus offset, saturated
	function automatic logic [31:0] raster_coord(logic signed [31:0] coord, logic [32:0] w,
			logic [31:0] f1, logic [31:0] f2, logic [31:0] f3, int sh,
			logic [15:0] res, logic signed [31:0] shift);
		logic [31:0]  mag;
		longint       term;
		longint       sum;
		mag = coord[31] ? -coord : coord;
		term = longint'(scaled_term(w, mag, f1, f2, f3, sh));
		sum = coord[31] ? -term : term;
		sum = sum + (longint'(res) <<< (FRAC - 1)) - longint'(shift);
		if (sum > 64'sd2147483647)
			sum = 64'sd2147483647;
		else if (sum < -64'sd2147483648)
			sum = -64'sd2147483648;
		return sum[31:0];
	endfunction

	function automatic raster_beat_t project_point(logic signed [31:0] x,
			logic signed [31:0] y, logic signed [31:0] z);
		raster_beat_t r;
		logic [32:0]  w;
		logic [32:0]  den;
		if (!cam_ortho && !z[31]) begin
			r = '{S32_MAX, S32_MAX, S32_MAX, 1'b1};
			return r;
		end
		if (cam_ortho) begin
			w = 33'(1) << FRAC;
			r.depth = z;
		end else begin
			den = 33'(-longint'(z));
			w = ((33'(1) << (2 * FRAC)) + den / 2) / den;
			r.depth = (w > 33'(S32_MAX)) ? S32_MAX : w[31:0];
		end
		r.rx = raster_coord(x, w, 32'(cam_focal), 32'(cam_width), 32'd1,
			FRAC, cam_width, cam_shift_x);
		r.ry = raster_coord(y, w, 32'(cam_focal), 32'(cam_aspect), 32'(cam_height),
			2 * FRAC, cam_height, cam_shift_y);
		r.behind = 1'b0;
		return r;
	endfunction

	// Clock and run limit
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Receiver: stall pattern follows a randomly chosen mode; long hold on request
	initial begin
		int mode;
		int mode_left;
		raster.ready = 1'b0;
		mode = 0;
		mode_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_cycles = 500;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 2);
				mode_left = 64;
			end
			mode_left--;
			if (hold_cycles > 0) begin
				hold_cycles--;
				raster.ready <= 1'b0;
			end else begin
				case (mode)
					0: raster.ready <= 1'b1;
					1: raster.ready <= ($urandom_range(0, 1) == 1);
					default: raster.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Output checker
	always @(posedge clk) begin
		raster_beat_t want;
		if (arst_n && raster.valid && raster.ready) begin
			if (pending_rasters.size() == 0) begin
				$error("unexpected raster beat x=%h y=%h", raster.raster_x, raster.raster_y);
				failed = 1'b1;
			end else begin
				want = pending_rasters.pop_front();
				if (raster.raster_x !== want.rx) begin
					$error("raster_x expected %h actual %h", want.rx, raster.raster_x);
					failed = 1'b1;
				end
				if (raster.raster_y !== want.ry) begin
					$error("raster_y expected %h actual %h", want.ry, raster.raster_y);
					failed = 1'b1;
				end
				if (raster.depth_out !== want.depth) begin
					$error("depth_out expected %h actual %h", want.depth, raster.depth_out);
					failed = 1'b1;
				end
				if (raster.behind_camera !== want.behind) begin
					$error("behind_camera expected %b actual %b", want.behind,
						raster.behind_camera);
					failed = 1'b1;
				end
			end
		end
	end

	// Register write; valid stays high until cam_write_done
	task automatic cam_write(cfg_idx_t idx, logic [31:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= data;
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			CFG_APERTURE: cam_aperture = data[30:0];
			CFG_FOCAL:    cam_focal = data[30:0];
			CFG_ASPECT:   cam_aspect = data[30:0];
			CFG_WIDTH:    cam_width = data[15:0];
			CFG_HEIGHT:   cam_height = data[15:0];
			CFG_SHIFT_X:  cam_shift_x = data;
			CFG_SHIFT_Y:  cam_shift_y = data;
			CFG_ORTHO:    cam_ortho = data[0];
			default: ;
		endcase
	endtask

	task automatic cam_write_done();
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Send one point; gaps fall between bursts of random length
	task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic known, raster_beat_t res);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				point.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		point.valid <= 1'b1;
		point.point_x <= x;
		point.point_y <= y;
		point.point_z <= z;
		do @(posedge clk); while (!point.ready);
		pending_rasters.push_back(known ? res : project_point(x, y, z));
		burst_left--;
	endtask

	task automatic wait_idle();
		point.valid <= 1'b0;
		while (pending_rasters.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
			default: return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
		endcase
	endfunction

	function automatic logic [31:0] rand_depth();
		case ($urandom_range(0, 9))
			0, 1: return $urandom();
			2: return -32'($urandom_range(1, 32'h100));
			default: return -32'($urandom_range(32'h100, 32'h0080_0000));
		endcase
	endfunction

	// Camera scale value: full range half the time, near unity otherwise
	function automatic logic [31:0] rand_scale();
		return $urandom_range(0, 1) ? $urandom() : $urandom_range(32'h2000, 32'h0008_0000);
	endfunction

	task automatic program_camera(int phase);
		case (phase)
			1: begin
				cam_write(CFG_APERTURE, 32'h7FFF_FFFF);
				cam_write(CFG_FOCAL, 32'h7FFF_FFFF);
				cam_write(CFG_ASPECT, 32'h7FFF_FFFF);
				cam_write(CFG_WIDTH, 32'h0000_FFFF);
				cam_write(CFG_HEIGHT, 32'h0000_FFFF);
				cam_write(CFG_SHIFT_X, 32'h7FFF_FFFF);
				cam_write(CFG_SHIFT_Y, 32'h8000_0000);
				cam_write(CFG_ORTHO, 32'h0);
			end
			2: begin
				cam_write(CFG_APERTURE, 32'h1);
				cam_write(CFG_FOCAL, 32'h1);
				cam_write(CFG_ASPECT, 32'h1);
				cam_write(CFG_WIDTH, 32'h1);
				cam_write(CFG_HEIGHT, 32'h1);
				cam_write(CFG_SHIFT_X, 32'h8000_0000);
				cam_write(CFG_SHIFT_Y, 32'h7FFF_FFFF);
				cam_write(CFG_ORTHO, 32'h1);
			end
			3: begin
				// aperture wraps to zero, which acts as one
				cam_write(CFG_APERTURE, 32'h8000_0000);
				cam_write(CFG_FOCAL, 32'h0001_0000);
				cam_write(CFG_WIDTH, 32'h0000_0780);
				cam_write(CFG_HEIGHT, 32'h0000_0438);
				cam_write(CFG_ORTHO, 32'h0);
			end
			default: begin
				cam_write(CFG_APERTURE, rand_scale());
				cam_write(CFG_FOCAL, rand_scale());
				cam_write(CFG_ASPECT, rand_scale());
				cam_write(CFG_WIDTH, $urandom_range(0, 1) ? $urandom() : $urandom_range(1, 4096));
				cam_write(CFG_HEIGHT, $urandom_range(0, 1) ? $urandom() : $urandom_range(1, 4096));
				cam_write(CFG_SHIFT_X, rand_coord());
				cam_write(CFG_SHIFT_Y, rand_coord());
				cam_write(CFG_ORTHO, $urandom());
			end
		endcase
		cam_write_done();
	endtask

	// Main stimulus
	initial begin
		int per_phase;
		failed = 1'b0;
		cycle_count = 0;
		burst_left = 0;
		hold_cycles = 0;
		hold_request = 1'b0;
		arst_n = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = CFG_APERTURE;
		cfg.data = '0;
		point.valid = 1'b0;
		point.point_x = '0;
		point.point_y = '0;
		point.point_z = '0;
		cam_aperture = 31'h1_0000;
		cam_focal = 31'h1_0000;
		cam_aspect = 31'h1_0000;
		cam_width = 16'd640;
		cam_height = 16'd480;
		cam_shift_x = '0;
		cam_shift_y = '0;
		cam_ortho = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i])
			send_point(DIRECTED[i].x, DIRECTED[i].y, DIRECTED[i].z,
				DIRECTED[i].known, DIRECTED[i].res);

		per_phase = RAND_POINTS / NUM_PHASES;
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph > 0) begin
				wait_idle();
				program_camera(ph);
			end
			if (ph == 1)
				hold_request = 1'b1;
			for (int n = 0; n < per_phase; n++)
				send_point(rand_coord(), rand_coord(), rand_depth(), 1'b0, '0);
		end
		point.valid <= 1'b0;

		while (pending_rasters.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (!failed && pending_rasters.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== camera_point_to_raster_core.f =====
src/cptr_pkg.sv
src/cptr_if.sv
src/cptr_dly.sv
src/cptr_mul.sv
src/cptr_div.sv
src/cptr_rnd.sv
src/camera_point_to_raster_core.sv
tb/sv/testbench.sv
